### design/goal_pkg.sv
// shared types and constants for the gyro outlier-rejecting adaptive low-pass filter
package goal_pkg;

  // field widths
  localparam int RateW  = 24;
  localparam int LimitW = 23;
  localparam int CoeffW = 17;
  localparam int FracW  = 16;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  // coefficient value that means 1.0
  localparam logic [CoeffW-1:0] CoeffOne = CoeffW'(65536);

  // reset values of the configuration registers
  localparam logic [LimitW-1:0] OutlierLimitRst = LimitW'(655360);
  localparam logic [LimitW-1:0] HeavyLimitRst   = LimitW'(131072);
  localparam logic [CoeffW-1:0] LightCoeffRst   = CoeffW'(13107);
  localparam logic [CoeffW-1:0] HeavyCoeffRst   = CoeffW'(3277);

  // register indexes, byte address is 4 times the index
  typedef enum logic [1:0] {
    REG_OUTLIER_LIMIT = 2'd0,
    REG_HEAVY_LIMIT   = 2'd1,
    REG_LIGHT_COEFF   = 2'd2,
    REG_HEAVY_COEFF   = 2'd3
  } reg_idx_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [LimitW-1:0] outlier_limit;
    logic [LimitW-1:0] heavy_limit;
    logic [CoeffW-1:0] light_coeff;
    logic [CoeffW-1:0] heavy_coeff;
  } cfg_t;

endpackage

### design/goal_cfg.sv
// configuration register file with an apb-style access port
module goal_cfg
  import goal_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = regs;

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.outlier_limit <= OutlierLimitRst;
      regs.heavy_limit   <= HeavyLimitRst;
      regs.light_coeff   <= LightCoeffRst;
      regs.heavy_coeff   <= HeavyCoeffRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_OUTLIER_LIMIT: regs.outlier_limit <= pwdata[LimitW-1:0];
        REG_HEAVY_LIMIT:   regs.heavy_limit   <= pwdata[LimitW-1:0];
        REG_LIGHT_COEFF:   regs.light_coeff   <= pwdata[CoeffW-1:0];
        REG_HEAVY_COEFF:   regs.heavy_coeff   <= pwdata[CoeffW-1:0];
        default: ;
      endcase
    end
  end

  // read data mux
  always_comb begin
    unique case (idx)
      REG_OUTLIER_LIMIT: prdata = DataW'(regs.outlier_limit);
      REG_HEAVY_LIMIT:   prdata = DataW'(regs.heavy_limit);
      REG_LIGHT_COEFF:   prdata = DataW'(regs.light_coeff);
      REG_HEAVY_COEFF:   prdata = DataW'(regs.heavy_coeff);
      default:           prdata = '0;
    endcase
  end

endmodule

### design/goal_core.sv
// filter datapath: outlier rejection, coefficient choice, smoothing step and filter state
module goal_core
  import goal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    advance,
  input  logic signed [RateW-1:0] sample,
  output logic signed [RateW-1:0] result
);

  localparam int DiffW = RateW + 1;
  localparam int ProdW = DiffW + CoeffW + 1;
  localparam int SumW  = ProdW - FracW;

  logic signed [RateW-1:0]  last_accepted;
  logic signed [RateW-1:0]  last_output;
  logic signed [DiffW-1:0]  jump;
  logic        [DiffW-1:0]  jump_abs;
  logic signed [RateW-1:0]  x_acc;
  logic signed [DiffW-1:0]  dev;
  logic        [DiffW-1:0]  dev_abs;
  logic        [CoeffW-1:0] coeff_sel;
  logic        [CoeffW-1:0] alpha;
  logic signed [ProdW-1:0]  prod;
  logic signed [SumW-1:0]   step;
  logic signed [SumW-1:0]   sum;

  // reject a sample that jumps too far from the last accepted one
  assign jump     = DiffW'(sample) - DiffW'(last_accepted);
  assign jump_abs = jump[DiffW-1] ? DiffW'(-jump) : DiffW'(jump);
  assign x_acc    = (jump_abs > DiffW'(cfg.outlier_limit)) ? last_accepted : sample;

  // heavy smoothing when far from the last output
  assign dev       = DiffW'(x_acc) - DiffW'(last_output);
  assign dev_abs   = dev[DiffW-1] ? DiffW'(-dev) : DiffW'(dev);
  assign coeff_sel = (dev_abs > DiffW'(cfg.heavy_limit)) ? cfg.heavy_coeff : cfg.light_coeff;
  assign alpha     = (coeff_sel > CoeffOne) ? CoeffOne : coeff_sel;

  // out = last + floor(alpha * dev / 2^16), stays between last output and accepted sample
  assign prod   = signed'({1'b0, alpha}) * dev;
  assign step   = prod[ProdW-1:FracW];
  assign sum    = SumW'(last_output) + step;
  assign result = sum[RateW-1:0];

  // filter state follows each item as it completes
  always_ff @(posedge clk) begin
    if (rst) begin
      last_accepted <= '0;
      last_output   <= '0;
    end else if (advance) begin
      last_accepted <= x_acc;
      last_output   <= result;
    end
  end

endmodule

### design/gyro_outlier_adaptive_lowpass.sv
// top level of the gyro outlier-rejecting adaptive low-pass filter
//
// one angular-rate channel, Q.16 rad/s samples in, smoothed Q.16 samples out
// input stream: s_tvalid/s_tready/s_tdata, one sample per transfer
// output stream: m_tvalid/m_tready/m_tdata, exactly one result per sample, in order
// configuration: apb-style port, outlier limit at 0x0, heavy limit at 0x4,
//   light coefficient at 0x8, heavy coefficient at 0xc; write only while idle
// a sample is captured in an input register; the filter step (compare, select,
//   multiply, add) runs between that register and the output register
// order: a sample's transfer loads the input register, and advance then loads its
//   result into the output register, which drives m_tvalid
// throughput: one sample per cycle while m_tready is high, set by the
//   combinational step that updates last accepted sample and last output per result
// when the receiver stalls the output register holds its result and one more
//   sample can still be taken into the input register before s_tready drops
// reset (rst, synchronous) empties both registers, clears the filter state to
//   zero and loads the register defaults
module gyro_outlier_adaptive_lowpass
  import goal_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // slave side, tdata: rate_sample[23:0]
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [RateW-1:0] s_tdata,
  // master side, tdata: smoothed_rate[23:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [RateW-1:0] m_tdata,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t                    cfg;
  logic                    in_valid;
  logic signed [RateW-1:0] in_sample;
  logic                    out_valid;
  logic [RateW-1:0]        out_data;
  logic                    advance;
  logic signed [RateW-1:0] result;

  goal_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // item moves from input register to output register
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  goal_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .sample  (in_sample),
    .result  (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= signed'(s_tdata);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule
